// ===== rtl/fmbq_pkg.sv =====
`timescale 1ns / 1ps

package fmbq_pkg;

	localparam int CAPACITY    = 64;
	localparam int VALUE_WIDTH = 32;

	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ACTION_W = 3;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 7;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH_FRONT  = 3'd0,
		ACT_PUSH_MIDDLE = 3'd1,
		ACT_PUSH_BACK   = 3'd2,
		ACT_POP_FRONT   = 3'd3,
		ACT_POP_MIDDLE  = 3'd4,
		ACT_POP_BACK    = 3'd5
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -1;

	// Broadcast to every cell: shift right from pos on insert, left from pos on remove.
	typedef struct packed {
		logic                   ins;
		logic                   rem;
		logic [IDX_W-1:0]       pos;
		logic [VALUE_WIDTH-1:0] val;
	} shift_cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] pop_value;
		logic [STATUS_W-1:0]      status;
		logic [OCC_W-1:0]         occupancy;
	} result_t;

endpackage

// ===== rtl/fmbq_if.sv =====
`timescale 1ns / 1ps

interface fmbq_req_if;
	import fmbq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [ACTION_W-1:0]      action;
	logic signed [DATA_W-1:0] push_value;

	modport source (output valid, output action, output push_value, input ready);
	modport sink (input valid, input action, input push_value, output ready);
endinterface

interface fmbq_rsp_if;
	import fmbq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] pop_value;
	logic [STATUS_W-1:0]      status;
	logic [OCC_W-1:0]         occupancy;

	modport source (output valid, output pop_value, output status, output occupancy,
		input ready);
	modport sink (input valid, input pop_value, input status, input occupancy,
		output ready);
endinterface

// ===== rtl/fmbq_cell.sv =====
`timescale 1ns / 1ps

module fmbq_cell (
	input  logic                             clk,
	input  logic [fmbq_pkg::IDX_W-1:0]       idx,
	input  fmbq_pkg::shift_cmd_t             cmd,
	input  logic [fmbq_pkg::VALUE_WIDTH-1:0] left_value,
	input  logic [fmbq_pkg::VALUE_WIDTH-1:0] right_value,
	output logic [fmbq_pkg::VALUE_WIDTH-1:0] value,
	output logic [fmbq_pkg::VALUE_WIDTH-1:0] rd_value
);
	import fmbq_pkg::*;

	logic [VALUE_WIDTH-1:0] value_q;
	logic                   at_pos;
	logic                   past_pos;

	assign at_pos   = (idx == cmd.pos);
	assign past_pos = (idx > cmd.pos);

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (at_pos) begin
				value_q <= cmd.val;
			end else if (past_pos) begin
				value_q <= left_value;
			end
		end else if (cmd.rem) begin
			if (at_pos || past_pos) begin
				value_q <= right_value;
			end
		end
	end

	assign value    = value_q;
	assign rd_value = at_pos ? value_q : '0;
endmodule

// ===== rtl/fmbq_ctrl.sv =====
`timescale 1ns / 1ps

module fmbq_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             fire,
	input  logic [fmbq_pkg::ACTION_W-1:0]    action,
	input  logic signed [fmbq_pkg::DATA_W-1:0] push_value,
	input  logic [fmbq_pkg::VALUE_WIDTH-1:0] rd_value,
	output fmbq_pkg::shift_cmd_t             cmd,
	output fmbq_pkg::result_t                result
);
	import fmbq_pkg::*;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic              full;
	logic              empty;
	logic              is_push;
	logic              is_pop;
	logic [CNT_W-1:0]  pos_wide;
	logic [CNT_W-1:0]  last;

	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);
	assign last  = empty ? '0 : count_q - CNT_W'(1);

	always_comb begin
		is_push  = 1'b0;
		is_pop   = 1'b0;
		pos_wide = '0;
		case (action)
			ACT_PUSH_FRONT: begin
				is_push = 1'b1;
			end
			ACT_PUSH_MIDDLE: begin
				is_push  = 1'b1;
				pos_wide = count_q >> 1;
			end
			ACT_PUSH_BACK: begin
				is_push  = 1'b1;
				pos_wide = count_q;
			end
			ACT_POP_FRONT: begin
				is_pop = 1'b1;
			end
			ACT_POP_MIDDLE: begin
				is_pop   = 1'b1;
				pos_wide = last >> 1;
			end
			ACT_POP_BACK: begin
				is_pop   = 1'b1;
				pos_wide = last;
			end
			default: begin
			end
		endcase
	end

	// A back push only reaches pos == CAPACITY when full, and then nothing moves.
	assign cmd.pos = pos_wide[IDX_W-1:0];
	assign cmd.ins = fire && is_push && !full;
	assign cmd.rem = fire && is_pop && !empty;
	assign cmd.val = VALUE_WIDTH'(push_value);

	always_comb begin
		count_d = count_q;
		if (cmd.ins) begin
			count_d = count_q + CNT_W'(1);
		end else if (cmd.rem) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_comb begin
		result.pop_value = '0;
		result.status    = ST_DONE;
		result.occupancy = OCC_W'(count_d);
		if (is_push && full) begin
			result.status = ST_FULL;
		end else if (is_pop && empty) begin
			result.status    = ST_EMPTY;
			result.pop_value = EMPTY_VALUE;
		end else if (is_pop) begin
			result.pop_value = DATA_W'($signed(rd_value));
		end
	end
endmodule

// ===== rtl/front_middle_back_queue.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Payload                                Handshake
// req      in         action[2:0], push_value[31:0]          valid / ready
// rsp      out        pop_value[31:0], status[1:0], occ[6:0]  valid / ready
//
// For every request, the whole row of cells shifts in parallel at the clock edge that
// accepts it, and its result appears in the output register next cycle.
// A new request is taken in the same cycle as the previous result leaves.
// Reset clears the occupancy and the output valid; cell contents are left as they are.
// While rsp is stalled, req.ready stays low and the queue holds.

module front_middle_back_queue (
	input logic        clk,
	input logic        arst_n,
	fmbq_req_if.sink   req,
	fmbq_rsp_if.source rsp
);
	import fmbq_pkg::*;

	logic                   fire;
	shift_cmd_t             cmd;
	result_t                result;
	logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
	logic [VALUE_WIDTH-1:0] cell_rd [CAPACITY];
	logic [VALUE_WIDTH-1:0] rd_value;
	logic                   rsp_valid_q;
	result_t                rsp_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;

	fmbq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.action     (req.action),
		.push_value (req.push_value),
		.rd_value   (rd_value),
		.cmd        (cmd),
		.result     (result)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_WIDTH-1:0] left_value;
		logic [VALUE_WIDTH-1:0] right_value;

		if (i == 0) begin : g_first
			assign left_value = '0;
		end else begin : g_inner_l
			assign left_value = cell_value[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_value = '0;
		end else begin : g_inner_r
			assign right_value = cell_value[i+1];
		end

		fmbq_cell u_cell (
			.clk         (clk),
			.idx         (IDX_W'(i)),
			.cmd         (cmd),
			.left_value  (left_value),
			.right_value (right_value),
			.value       (cell_value[i]),
			.rd_value    (cell_rd[i])
		);
	end

	// Only the cell at the command position drives a nonzero read value.
	always_comb begin
		rd_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_value = rd_value | cell_rd[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= result;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.pop_value = rsp_q.pop_value;
	assign rsp.status    = rsp_q.status;
	assign rsp.occupancy = rsp_q.occupancy;
endmodule

// ===== rtl/fmbq_checker.sv =====
`timescale 1ns / 1ps

module fmbq_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             req_valid,
	input logic                             req_ready,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input logic signed [fmbq_pkg::DATA_W-1:0] pop_value,
	input logic [fmbq_pkg::STATUS_W-1:0]    status,
	input logic [fmbq_pkg::OCC_W-1:0]       occupancy
);
	import fmbq_pkg::*;

	// A waiting result is never overwritten by a new request.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |-> (!rsp_valid || rsp_ready))
		else $error("request accepted over a stalled result");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(pop_value)
			&& $stable(status) && $stable(occupancy)))
		else $error("stalled result changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == ST_EMPTY) |-> (pop_value == EMPTY_VALUE && occupancy == '0))
		else $error("empty pop reported with wrong value or occupancy");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == ST_FULL) |-> (pop_value == '0
			&& occupancy == OCC_W'(CAPACITY)))
		else $error("dropped push reported with wrong value or occupancy");
endmodule

bind front_middle_back_queue fmbq_checker u_fmbq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.pop_value (rsp.pop_value),
	.status    (rsp.status),
	.occupancy (rsp.occupancy)
);
